// File: sv/fdf_pkg.sv
// ----------------------------------------------------------------------------
// fdf_pkg
// Shared types and constants of the fall detector: register map, reset
// values, the classified sample that passes front to back, and the result.
// ----------------------------------------------------------------------------
package fdf_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_FF_LIMIT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMP_LIMIT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_STILL_LO  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STILL_HI  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FF_MIN    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_IMP_WIN   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_STILL_WIN = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_MOTION    = 3'd7;

    localparam logic [31:0] RST_FF_LIMIT  = 32'd1509949;
    localparam logic [31:0] RST_IMP_LIMIT = 32'd16777216;
    localparam logic [31:0] RST_STILL_LO  = 32'd2055209;
    localparam logic [31:0] RST_STILL_HI  = 32'd7088374;
    localparam logic [7:0]  RST_FF_MIN    = 8'd3;
    localparam logic [15:0] RST_IMP_WIN   = 16'd50;
    localparam logic [15:0] RST_STILL_WIN = 16'd100;
    localparam logic [7:0]  RST_MOTION    = 8'd15;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic [31:0] ff_limit;
        logic [31:0] imp_limit;
        logic [31:0] still_lo;
        logic [31:0] still_hi;
        logic [7:0]  ff_min;
        logic [15:0] imp_win;
        logic [15:0] still_win;
        logic [7:0]  motion_tol;
    } fdf_cfg_t;

    typedef struct packed {
        logic is_clear;
        logic is_low;
        logic is_impact;
        logic is_band;
    } fdf_class_t;

    typedef struct packed {
        logic       detected;
        logic [1:0] phase;
    } fdf_result_t;

endpackage

// File: sv/fdf_regs.sv
// ----------------------------------------------------------------------------
// fdf_regs
// APB-style configuration registers: thresholds, counts and windows.
// ----------------------------------------------------------------------------
module fdf_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fdf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output fdf_pkg::fdf_cfg_t              cfg
);
    import fdf_pkg::*;

    fdf_cfg_t              cfg_reg;
    fdf_cfg_t              cfg_next;
    logic [REG_IDX_W-1:0]  idx;
    logic                  wr_en;

    assign idx    = paddr[CFG_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_FF_LIMIT:  cfg_next.ff_limit   = pwdata;
                REG_IMP_LIMIT: cfg_next.imp_limit  = pwdata;
                REG_STILL_LO:  cfg_next.still_lo   = pwdata;
                REG_STILL_HI:  cfg_next.still_hi   = pwdata;
                REG_FF_MIN:    cfg_next.ff_min     = pwdata[7:0];
                REG_IMP_WIN:   cfg_next.imp_win    = pwdata[15:0];
                REG_STILL_WIN: cfg_next.still_win  = pwdata[15:0];
                REG_MOTION:    cfg_next.motion_tol = pwdata[7:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_FF_LIMIT:  prdata = cfg_reg.ff_limit;
            REG_IMP_LIMIT: prdata = cfg_reg.imp_limit;
            REG_STILL_LO:  prdata = cfg_reg.still_lo;
            REG_STILL_HI:  prdata = cfg_reg.still_hi;
            REG_FF_MIN:    prdata = {24'd0, cfg_reg.ff_min};
            REG_IMP_WIN:   prdata = {16'd0, cfg_reg.imp_win};
            REG_STILL_WIN: prdata = {16'd0, cfg_reg.still_win};
            REG_MOTION:    prdata = {24'd0, cfg_reg.motion_tol};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ff_limit   <= RST_FF_LIMIT;
            cfg_reg.imp_limit  <= RST_IMP_LIMIT;
            cfg_reg.still_lo   <= RST_STILL_LO;
            cfg_reg.still_hi   <= RST_STILL_HI;
            cfg_reg.ff_min     <= RST_FF_MIN;
            cfg_reg.imp_win    <= RST_IMP_WIN;
            cfg_reg.still_win  <= RST_STILL_WIN;
            cfg_reg.motion_tol <= RST_MOTION;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: sv/fdf_front.sv
// ----------------------------------------------------------------------------
// fdf_front
// Sample classifier: abs, squares, magnitude sum and threshold compares,
// three register stages. Never stalls; admission is credit based upstream.
// ----------------------------------------------------------------------------
module fdf_front #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           op,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_z,
    input  fdf_pkg::fdf_cfg_t              cfg,
    output logic                           cls_valid,
    output fdf_pkg::fdf_class_t            cls,
    output logic [1:0]                     inflight
);
    import fdf_pkg::*;

    localparam int W     = SAMPLE_WIDTH;
    localparam int SQ_W  = 2 * W;
    localparam int MAG_W = SQ_W + 2;
    localparam int CMP_W = (MAG_W > 32) ? MAG_W : 32;

    logic [W-1:0]     abs_x, abs_y, abs_z;
    logic             v1_reg, v2_reg, v3_reg;
    logic             op1_reg, op2_reg;
    logic [W-1:0]     ax1_reg, ay1_reg, az1_reg;
    logic [SQ_W-1:0]  sx2_reg, sy2_reg, sz2_reg;
    logic [MAG_W-1:0] mag;
    logic [CMP_W-1:0] mag_c;
    fdf_class_t       cls_next;
    fdf_class_t       cls3_reg;

    always_comb
    begin
        abs_x = accel_x[W-1] ? W'(~$unsigned(accel_x) + 1'b1) : $unsigned(accel_x);
        abs_y = accel_y[W-1] ? W'(~$unsigned(accel_y) + 1'b1) : $unsigned(accel_y);
        abs_z = accel_z[W-1] ? W'(~$unsigned(accel_z) + 1'b1) : $unsigned(accel_z);
    end

    always_comb
    begin
        mag   = MAG_W'(sx2_reg) + MAG_W'(sy2_reg) + MAG_W'(sz2_reg);
        mag_c = CMP_W'(mag);
        cls_next.is_clear  = (op2_reg == OP_CLEAR);
        cls_next.is_low    = mag_c < CMP_W'(cfg.ff_limit);
        cls_next.is_impact = mag_c > CMP_W'(cfg.imp_limit);
        cls_next.is_band   = (mag_c >= CMP_W'(cfg.still_lo)) &&
                             (mag_c <= CMP_W'(cfg.still_hi));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op1_reg  <= op;
        ax1_reg  <= abs_x;
        ay1_reg  <= abs_y;
        az1_reg  <= abs_z;
        op2_reg  <= op1_reg;
        sx2_reg  <= SQ_W'(ax1_reg) * SQ_W'(ax1_reg);
        sy2_reg  <= SQ_W'(ay1_reg) * SQ_W'(ay1_reg);
        sz2_reg  <= SQ_W'(az1_reg) * SQ_W'(az1_reg);
        cls3_reg <= cls_next;
    end

    assign cls_valid = v3_reg;
    assign cls       = cls3_reg;
    assign inflight  = {1'b0, v1_reg} + {1'b0, v2_reg} + {1'b0, v3_reg};

endmodule

// File: sv/fdf_fifo.sv
// ----------------------------------------------------------------------------
// fdf_fifo
// Small first-word-fall-through queue, power-of-two depth, with fill count.
// ----------------------------------------------------------------------------
module fdf_fifo #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = slot_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

// File: sv/fdf_back.sv
// ----------------------------------------------------------------------------
// fdf_back
// Detector state machine: normal, free-fall, impact, confirmed, with
// saturating run, window and motion-streak counters; one beat per go cycle.
// ----------------------------------------------------------------------------
module fdf_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  fdf_pkg::fdf_class_t  cls,
    input  fdf_pkg::fdf_cfg_t    cfg,
    output fdf_pkg::fdf_result_t res
);
    import fdf_pkg::*;

    typedef enum logic [1:0] {
        PH_NORMAL    = 2'd0,
        PH_FREEFALL  = 2'd1,
        PH_IMPACT    = 2'd2,
        PH_CONFIRMED = 2'd3
    } phase_t;

    localparam logic [7:0]  CNT8_MAX  = 8'hFF;
    localparam logic [16:0] CNT17_MAX = 17'h1FFFF;

    phase_t      phase_reg, phase_next;
    logic [7:0]  low_run_reg, low_run_next;
    logic [16:0] window_reg, window_next;
    logic [7:0]  streak_reg, streak_next;
    logic [7:0]  low_run_inc, streak_inc;
    logic [16:0] window_inc;
    logic        detected;

    always_comb
    begin
        low_run_inc = (low_run_reg == CNT8_MAX) ? low_run_reg : low_run_reg + 1'b1;
        streak_inc  = (streak_reg == CNT8_MAX) ? streak_reg : streak_reg + 1'b1;
        window_inc  = (window_reg == CNT17_MAX) ? window_reg : window_reg + 1'b1;

        phase_next   = phase_reg;
        low_run_next = low_run_reg;
        window_next  = window_reg;
        streak_next  = streak_reg;
        detected     = 1'b0;

        if (cls.is_clear)
        begin
            phase_next   = PH_NORMAL;
            low_run_next = '0;
            window_next  = '0;
            streak_next  = '0;
        end
        else
        begin
            case (phase_reg)
                PH_NORMAL:
                begin
                    if (cls.is_low)
                    begin
                        low_run_next = low_run_inc;
                        if (low_run_inc >= cfg.ff_min)
                        begin
                            phase_next  = PH_FREEFALL;
                            window_next = '0;
                        end
                    end
                    else
                    begin
                        low_run_next = '0;
                    end
                end
                PH_FREEFALL:
                begin
                    window_next = window_inc;
                    if (cls.is_impact)
                    begin
                        phase_next  = PH_IMPACT;
                        window_next = '0;
                        streak_next = '0;
                    end
                    else if (window_inc > {1'b0, cfg.imp_win})
                    begin
                        phase_next   = PH_NORMAL;
                        low_run_next = '0;
                    end
                end
                PH_IMPACT:
                begin
                    window_next = window_inc;
                    if (cls.is_band)
                    begin
                        streak_next = '0;
                        if (window_inc >= {1'b0, cfg.still_win})
                        begin
                            phase_next = PH_CONFIRMED;
                            detected   = 1'b1;
                        end
                    end
                    else
                    begin
                        streak_next = streak_inc;
                        if (streak_inc >= cfg.motion_tol)
                        begin
                            phase_next   = PH_NORMAL;
                            low_run_next = '0;
                            streak_next  = '0;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        res.detected = detected;
        res.phase    = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_NORMAL;
            low_run_reg <= '0;
            window_reg  <= '0;
            streak_reg  <= '0;
        end
        else if (go)
        begin
            phase_reg   <= phase_next;
            low_run_reg <= low_run_next;
            window_reg  <= window_next;
            streak_reg  <= streak_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_detect_confirms: assert property (@(posedge clk) disable iff (!rst_n)
        (go && res.detected) |-> (res.phase == PH_CONFIRMED))
        else $error("detection without confirmed phase");
`endif

endmodule

// File: sv/fall_detector_fsm_core.sv
// ----------------------------------------------------------------------------
// fall_detector_fsm_core
// Path: an accepted beat runs through three classifier stages and the class
// queue; one state-machine step queues its result. Throughput: one beat per
// cycle unless the class queue is empty or the result queue is full.
// Reset: asynchronous, clears queues, state and counters; registers reload.
// ----------------------------------------------------------------------------
module fall_detector_fsm_core #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int CQ_DEPTH     = 8,
    parameter int RQ_DEPTH     = 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           op,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_z,
    output logic                           empty,
    input  logic                           pop,
    output logic                           fall_detected,
    output logic [1:0]                     phase,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fdf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import fdf_pkg::*;

    localparam int CQ_CW = $clog2(CQ_DEPTH + 1);
    localparam int RQ_CW = $clog2(RQ_DEPTH + 1);

    fdf_cfg_t          cfg;
    logic              in_ok;
    logic              cls_valid;
    fdf_class_t        cls;
    fdf_class_t        cq_head;
    logic [1:0]        inflight;
    logic [CQ_CW-1:0]  cq_count;
    logic [RQ_CW-1:0]  rq_count;
    logic [CQ_CW:0]    credit_used;
    logic              cq_empty;
    logic              rq_full;
    logic              back_go;
    logic              rq_pop;
    fdf_result_t       back_res;
    fdf_result_t       rq_head;

    assign credit_used = (CQ_CW + 1)'(cq_count) + (CQ_CW + 1)'(inflight);
    assign full        = credit_used >= (CQ_CW + 1)'(CQ_DEPTH);
    assign in_ok       = push && !full;
    assign cq_empty    = (cq_count == '0);
    assign rq_full     = (rq_count == RQ_CW'(RQ_DEPTH));
    assign empty       = (rq_count == '0);
    assign rq_pop      = pop && !empty;
    assign back_go     = !cq_empty && !rq_full;

    assign fall_detected = rq_head.detected;
    assign phase         = rq_head.phase;

    fdf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fdf_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ok),
        .op        (op),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .cfg       (cfg),
        .cls_valid (cls_valid),
        .cls       (cls),
        .inflight  (inflight)
    );

    fdf_fifo #(
        .WIDTH ($bits(fdf_class_t)),
        .DEPTH (CQ_DEPTH)
    ) u_cls_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cls_valid),
        .wdata (cls),
        .pop   (back_go),
        .rdata (cq_head),
        .count (cq_count)
    );

    fdf_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (back_go),
        .cls   (cq_head),
        .cfg   (cfg),
        .res   (back_res)
    );

    fdf_fifo #(
        .WIDTH ($bits(fdf_result_t)),
        .DEPTH (RQ_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_go),
        .wdata (back_res),
        .pop   (rq_pop),
        .rdata (rq_head),
        .count (rq_count)
    );

`ifndef NO_ASSERTIONS
    a_cq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(cls_valid && (cq_count == CQ_CW'(CQ_DEPTH)) && !back_go))
        else $error("class queue overflow");

    a_rq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(back_go && rq_full && !rq_pop))
        else $error("result queue overflow");

    a_result_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (back_go && !rq_pop) |=> !empty)
        else $error("pushed result not visible");
`endif

endmodule
